@@ rtl/lffm_pkg.sv @@
// Package for the link failsafe flight mode unit: codes, constants and payload types.
package lffm_pkg;

    // Flight modes.
    typedef enum logic [1:0] {
        MODE_OFF  = 2'd0,
        MODE_USER = 2'd1,
        MODE_DISC = 2'd2,
        MODE_LAND = 2'd3
    } mode_t;

    // Power command codes.
    localparam logic [1:0] PWR_NONE = 2'd0;
    localparam logic [1:0] PWR_ON   = 2'd1;
    localparam logic [1:0] PWR_OFF  = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] CFG_LINK_TIMEOUT = 3'd0;
    localparam logic [2:0] CFG_LONG_LOSS    = 3'd1;
    localparam logic [2:0] CFG_STILL_SPEED  = 3'd2;
    localparam logic [2:0] CFG_STILL_STEPS  = 3'd3;
    localparam logic [2:0] CFG_FLIP_ACCEL   = 3'd4;
    localparam logic [2:0] CFG_LANDING_SPD  = 3'd5;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    // Configuration reset values.
    localparam logic [31:0]        LINK_TIMEOUT_RST = 32'd500000;
    localparam logic [31:0]        LONG_LOSS_RST    = 32'd3000000;
    localparam logic [14:0]        STILL_SPEED_RST  = 15'd20;
    localparam logic [15:0]        STILL_STEPS_RST  = 16'd200;
    localparam logic signed [15:0] FLIP_ACCEL_RST   = -16'sd2048;
    localparam logic signed [15:0] LANDING_SPD_RST  = -16'sd50;

    // Ground test constants.
    localparam logic signed [15:0] LAND_SPEED_MAX = -16'sd10;
    localparam logic [15:0]        DECAY_STEP     = 16'd9;
    localparam logic [15:0]        STILL_TOP      = 16'hFFFF;

    // One input word: one control tick.
    typedef struct packed {
        logic [31:0]        now_us;
        logic               msg_valid;
        logic [1:0]         msg_power;
        logic signed [15:0] vertical_speed;
        logic signed [15:0] accel_z;
    } in_item_t;

    // One result word.
    typedef struct packed {
        logic [1:0] flight_mode;
        logic       link_up;
        logic [1:0] power_cmd;
        logic       send_reply;
    } out_item_t;

    // Configuration register set.
    typedef struct packed {
        logic [31:0]        link_timeout_us;
        logic [31:0]        long_loss_us;
        logic [14:0]        still_speed_limit;
        logic [15:0]        still_steps_needed;
        logic signed [15:0] flip_accel_limit;
        logic signed [15:0] descent_target;
    } cfg_t;

    // Persistent controller state.
    typedef struct packed {
        mode_t       mode;
        logic        connected;
        logic [1:0]  power;
        logic [31:0] last_msg_time;
        logic [31:0] lost_time;
        logic [15:0] still_count;
    } state_t;

endpackage

@@ rtl/link_failsafe_flight_mode_unit.sv @@
// Top level of the link failsafe flight mode unit: registers, handshakes and config port.
//
// Usage: each input word is one control tick (time stamp, pilot message flag and
// power command, vertical speed, accel Z). Every accepted word yields exactly one
// result word with the flight mode, link status, stored power command and the
// reply flag. Both channels use valid and stall; a word moves on a rising edge
// where valid is high and stall is low.
// An accepted input word sits in the input register until it advances; then the state
// update and the result register load together, and the result word becomes valid.
// Throughput is one word per cycle while the receiver does not stall; the state
// update is a single compare-and-select pass, so a tick can follow in the next cycle.
// When the receiver stalls, the result holds and one more word may sit in the
// input register; the input stalls only when both are full and the output is held.
// Configuration is written through cfg_we, cfg_index and cfg_data, one register per
// edge; the user must write it only while the unit is idle, which the block does not enforce.
// Indexes past the last register are ignored. Reset puts mode off, link down, power off,
// times and the still counter at zero, and loads the default configuration values.
module link_failsafe_flight_mode_unit
    import lffm_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  in_item_t               in_data,
    output logic                   out_valid,
    input  logic                   out_stall,
    output out_item_t              out_data,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t      cfg_reg;
    state_t    state_reg;
    state_t    state_next;
    in_item_t  in_data_reg;
    logic      in_valid_reg;
    out_item_t out_data_reg;
    out_item_t result_next;
    logic      out_valid_reg;
    logic      advance;

    // A buffered word advances when the result register is free or being taken.
    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.link_timeout_us    <= LINK_TIMEOUT_RST;
            cfg_reg.long_loss_us       <= LONG_LOSS_RST;
            cfg_reg.still_speed_limit  <= STILL_SPEED_RST;
            cfg_reg.still_steps_needed <= STILL_STEPS_RST;
            cfg_reg.flip_accel_limit   <= FLIP_ACCEL_RST;
            cfg_reg.descent_target     <= LANDING_SPD_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_LINK_TIMEOUT: cfg_reg.link_timeout_us    <= cfg_data;
                CFG_LONG_LOSS:    cfg_reg.long_loss_us       <= cfg_data;
                CFG_STILL_SPEED:  cfg_reg.still_speed_limit  <= cfg_data[14:0];
                CFG_STILL_STEPS:  cfg_reg.still_steps_needed <= cfg_data[15:0];
                CFG_FLIP_ACCEL:   cfg_reg.flip_accel_limit   <= cfg_data[15:0];
                CFG_LANDING_SPD:  cfg_reg.descent_target     <= cfg_data[15:0];
                default:          ;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_data_reg <= in_data;
        end
    end

    // Tick logic.
    lffm_core u_core (
        .st      (state_reg),
        .cfg     (cfg_reg),
        .item    (in_data_reg),
        .st_next (state_next),
        .result  (result_next)
    );

    // Controller state and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.mode          <= MODE_OFF;
            state_reg.connected     <= 1'b0;
            state_reg.power         <= PWR_OFF;
            state_reg.last_msg_time <= '0;
            state_reg.lost_time     <= '0;
            state_reg.still_count   <= '0;
            out_valid_reg           <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                state_reg <= state_next;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result register.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= result_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

@@ rtl/lffm_core.sv @@
// Next-state and result logic for one control tick of the flight mode unit.
module lffm_core
    import lffm_pkg::*;
(
    input  state_t    st,
    input  cfg_t      cfg,
    input  in_item_t  item,
    output state_t    st_next,
    output out_item_t result
);

    logic [31:0] since_msg;
    logic [31:0] since_loss;
    logic        link_lost;
    logic [16:0] vs_ext;
    logic [16:0] vs_mag;
    logic        is_still;
    logic [15:0] count_step;
    logic        on_ground;
    logic        flipped;
    logic        to_off;
    state_t      nx;

    // Message handling and link timeout.
    always_comb
    begin
        nx = st;
        if (item.msg_valid)
        begin
            nx.last_msg_time = item.now_us;
            nx.connected     = 1'b1;
            if (item.msg_power == PWR_ON || item.msg_power == PWR_OFF)
            begin
                nx.power = item.msg_power;
            end
        end
    end

    assign since_msg = item.now_us - nx.last_msg_time;
    assign link_lost = nx.connected && (since_msg > cfg.link_timeout_us);

    // Time since loss uses the loss time as updated in this tick.
    assign since_loss = item.now_us - (link_lost ? item.now_us : nx.lost_time);

    // Ground test: still ticks count up with saturation, others decay.
    assign vs_ext   = {item.vertical_speed[15], item.vertical_speed};
    assign vs_mag   = item.vertical_speed[15] ? (17'd0 - vs_ext) : vs_ext;
    assign is_still = ($signed(cfg.descent_target) <= $signed(LAND_SPEED_MAX))
                      && (vs_mag < {2'b00, cfg.still_speed_limit});

    always_comb
    begin
        if (is_still)
        begin
            count_step = (st.still_count != STILL_TOP) ? st.still_count + 16'd1
                                                       : st.still_count;
        end
        else
        begin
            count_step = (st.still_count > DECAY_STEP) ? st.still_count - DECAY_STEP
                                                       : 16'd0;
        end
    end

    assign on_ground = count_step >= cfg.still_steps_needed;
    assign flipped   = $signed(item.accel_z) <= $signed(cfg.flip_accel_limit);

    // Mode transitions and the forced shutdown.
    always_comb
    begin
        st_next = nx;
        to_off  = 1'b0;
        if (link_lost)
        begin
            st_next.connected = 1'b0;
            st_next.lost_time = item.now_us;
        end
        unique case (st.mode)
            MODE_OFF:
            begin
                if (st_next.connected && st_next.power == PWR_ON)
                begin
                    st_next.mode = MODE_USER;
                end
            end
            MODE_USER:
            begin
                if (st_next.connected)
                begin
                    if (st_next.power == PWR_OFF)
                    begin
                        to_off = 1'b1;
                    end
                end
                else if (since_loss <= cfg.long_loss_us)
                begin
                    st_next.mode = MODE_DISC;
                end
                else
                begin
                    st_next.mode        = MODE_LAND;
                    st_next.still_count = 16'd0;
                end
            end
            MODE_DISC:
            begin
                if (st_next.connected)
                begin
                    if (st_next.power == PWR_OFF)
                    begin
                        to_off = 1'b1;
                    end
                    else
                    begin
                        st_next.mode = MODE_USER;
                    end
                end
                else if (since_loss > cfg.long_loss_us)
                begin
                    st_next.mode        = MODE_LAND;
                    st_next.still_count = 16'd0;
                end
            end
            MODE_LAND:
            begin
                if (st_next.connected)
                begin
                    if (st_next.power == PWR_OFF)
                    begin
                        to_off = 1'b1;
                    end
                    else
                    begin
                        st_next.mode = MODE_USER;
                    end
                end
                else
                begin
                    st_next.still_count = count_step;
                    if (on_ground)
                    begin
                        to_off = 1'b1;
                    end
                end
            end
            default:
            begin
                st_next.mode = MODE_OFF;
            end
        endcase
        if (flipped || to_off)
        begin
            st_next.mode  = MODE_OFF;
            st_next.power = PWR_OFF;
        end
    end

    // Result word follows the updated state; the reply flag follows the tick's message flag.
    assign result.flight_mode = st_next.mode;
    assign result.link_up     = st_next.connected;
    assign result.power_cmd   = st_next.power;
    assign result.send_reply  = item.msg_valid;

endmodule
